// File: src/mm4x4_pkg.sv
`timescale 1ns / 1ps

package mm4x4_pkg;

  localparam int DIM_DEFAULT  = 4;
  localparam int FRAC_DEFAULT = 16;
  localparam int DATA_W       = 32;
  // Depth of the queue between the front and the back.
  localparam int IQ_DEPTH     = 4;
  // Depth of the result queue at the back's output.
  localparam int OQ_DEPTH     = 4;

  typedef enum logic {
    KIND_LOAD,
    KIND_TRIGGER
  } item_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

endpackage

// File: src/mm4x4_front.sv
`timescale 1ns / 1ps

module mm4x4_front
  import mm4x4_pkg::*;
#(
  parameter int MATRIX_DIM = DIM_DEFAULT,
  parameter int IDX_W      = $clog2(MATRIX_DIM * MATRIX_DIM)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IDX_W-1:0]         in_elem_index,
  input  logic signed [DATA_W-1:0] in_a_element,
  input  logic signed [DATA_W-1:0] in_b_element,
  output logic                     q_valid,
  output item_kind_t               q_kind,
  output logic [IDX_W-1:0]         q_idx,
  output logic [DATA_W-1:0]        q_a,
  output logic [DATA_W-1:0]        q_b,
  input  logic                     q_pop
);

  localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;
  localparam int PTR_W      = (IQ_DEPTH > 1) ? $clog2(IQ_DEPTH) : 1;
  localparam int CNT_W      = $clog2(IQ_DEPTH + 1);

  item_kind_t         kind_q [IQ_DEPTH];
  logic [IDX_W-1:0]   idx_q  [IQ_DEPTH];
  logic [DATA_W-1:0]  a_q    [IQ_DEPTH];
  logic [DATA_W-1:0]  b_q    [IQ_DEPTH];

  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               in_xfer;
  logic               push;
  logic               is_trigger;
  logic               in_range;

  assign in_ready   = (cnt_r < CNT_W'(IQ_DEPTH));
  assign in_xfer    = in_valid && in_ready;
  assign is_trigger = (in_elem_index == IDX_W'(ELEM_COUNT - 1));
  assign in_range   = ({1'b0, in_elem_index} < (IDX_W + 1)'(ELEM_COUNT));
  // Items beyond the stores are taken and dropped here; they never reach the back.
  assign push       = in_xfer && in_range;

  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wr_ptr_r] <= is_trigger ? KIND_TRIGGER : KIND_LOAD;
      idx_q[wr_ptr_r]  <= in_elem_index;
      a_q[wr_ptr_r]    <= in_a_element;
      b_q[wr_ptr_r]    <= in_b_element;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(IQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(IQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_kind  = kind_q[rd_ptr_r];
  assign q_idx   = idx_q[rd_ptr_r];
  assign q_a     = a_q[rd_ptr_r];
  assign q_b     = b_q[rd_ptr_r];

endmodule

// File: src/mm4x4_back.sv
`timescale 1ns / 1ps

module mm4x4_back
  import mm4x4_pkg::*;
#(
  parameter int MATRIX_DIM = DIM_DEFAULT,
  parameter int FRAC_BITS  = FRAC_DEFAULT,
  parameter int IDX_W      = $clog2(MATRIX_DIM * MATRIX_DIM)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  item_kind_t               q_kind,
  input  logic [IDX_W-1:0]         q_idx,
  input  logic [DATA_W-1:0]        q_a,
  input  logic [DATA_W-1:0]        q_b,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_index,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_saturated,
  output logic                     out_last_of_run
);

  localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;
  localparam int DIM_W      = $clog2(MATRIX_DIM);
  localparam int ACC_W      = 2 * DATA_W + $clog2(MATRIX_DIM);
  localparam int OQ_PTR_W   = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

  bk_state_t state_r, state_nxt;

  // Element stores. An entry whose valid bit is clear reads as zero.
  logic [DATA_W-1:0]     a_mem [ELEM_COUNT];
  logic [DATA_W-1:0]     b_mem [ELEM_COUNT];
  logic [ELEM_COUNT-1:0] elem_vld_r;
  logic                  wr_en;

  logic [DIM_W-1:0] r_r, c_r, k_r;
  logic [IDX_W-1:0] n_r;
  logic             k_last, c_last, r_last, n_last;
  logic             issue;
  logic [IDX_W-1:0] a_addr, b_addr;

  logic [OQ_CNT_W-1:0] res_cnt_r;

  logic                     s1_vld_r, s1_first_r, s1_lastk_r, s1_lastrun_r;
  logic [IDX_W-1:0]         s1_n_r;
  logic [DATA_W-1:0]        a_rd_r, b_rd_r;
  logic                     a_ok_r, b_ok_r;
  logic signed [DATA_W-1:0] a_m, b_m;

  logic                       s2_vld_r, s2_first_r, s2_lastk_r, s2_lastrun_r;
  logic [IDX_W-1:0]           s2_n_r;
  logic signed [2*DATA_W-1:0] prod_r;

  logic signed [ACC_W-1:0] acc_r;
  logic                    s3_done_r, s3_lastrun_r;
  logic [IDX_W-1:0]        s3_n_r;

  logic signed [ACC_W-1:0]  acc_shift;
  logic [ACC_W-DATA_W:0]    sat_top;
  logic                     fits;
  logic [DATA_W-1:0]        sat_val;

  logic [IDX_W-1:0]    oq_idx  [OQ_DEPTH];
  logic [DATA_W-1:0]   oq_val  [OQ_DEPTH];
  logic                oq_sat  [OQ_DEPTH];
  logic                oq_last [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_ptr_r, oq_rd_ptr_r;
  logic [OQ_CNT_W-1:0] oq_cnt_r;
  logic                out_xfer;

  assign k_last = (k_r == DIM_W'(MATRIX_DIM - 1));
  assign c_last = (c_r == DIM_W'(MATRIX_DIM - 1));
  assign r_last = (r_r == DIM_W'(MATRIX_DIM - 1));
  assign n_last = (n_r == IDX_W'(ELEM_COUNT - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && q_kind == KIND_TRIGGER) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (issue && k_last && n_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // A new element starts only when a result slot is reserved for it.
  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop = q_valid;
      BK_RUN:  issue = (k_r != '0) || (res_cnt_r < OQ_CNT_W'(OQ_DEPTH));
      default: begin
        q_pop = 1'b0;
        issue = 1'b0;
      end
    endcase
  end

  assign wr_en = q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r <= '0;
      c_r <= '0;
      k_r <= '0;
      n_r <= '0;
    end else if (issue) begin
      if (k_last) begin
        k_r <= '0;
        n_r <= n_last ? '0 : n_r + 1'b1;
        if (c_last) begin
          c_r <= '0;
          r_r <= r_last ? '0 : r_r + 1'b1;
        end else begin
          c_r <= c_r + 1'b1;
        end
      end else begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  assign a_addr = IDX_W'(r_r) * IDX_W'(MATRIX_DIM) + IDX_W'(k_r);
  assign b_addr = IDX_W'(k_r) * IDX_W'(MATRIX_DIM) + IDX_W'(c_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      a_mem[q_idx] <= q_a;
    end
    a_rd_r <= a_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      b_mem[q_idx] <= q_b;
    end
    b_rd_r <= b_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_vld_r <= '0;
    end else if (wr_en) begin
      elem_vld_r[q_idx] <= 1'b1;
    end
  end

  // Stage 1: store read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    a_ok_r       <= elem_vld_r[a_addr];
    b_ok_r       <= elem_vld_r[b_addr];
    s1_first_r   <= (k_r == '0);
    s1_lastk_r   <= k_last;
    s1_lastrun_r <= n_last;
    s1_n_r       <= n_r;
  end

  assign a_m = a_ok_r ? signed'(a_rd_r) : '0;
  assign b_m = b_ok_r ? signed'(b_rd_r) : '0;

  // Stage 2: full-precision product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= a_m * b_m;
    s2_first_r   <= s1_first_r;
    s2_lastk_r   <= s1_lastk_r;
    s2_lastrun_r <= s1_lastrun_r;
    s2_n_r       <= s1_n_r;
  end

  // Stage 3: accumulate the products of one element.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_done_r <= 1'b0;
    end else begin
      s3_done_r <= s2_vld_r && s2_lastk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      acc_r <= s2_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
    s3_lastrun_r <= s2_lastrun_r;
    s3_n_r       <= s2_n_r;
  end

  // The arithmetic shift rounds toward minus infinity; the result fits when
  // every bit above the 32-bit sign position matches it.
  assign acc_shift = acc_r >>> FRAC_BITS;
  assign sat_top   = acc_shift[ACC_W-1:DATA_W-1];
  assign fits      = (&sat_top) || !(|sat_top);
  assign sat_val   = fits ? acc_shift[DATA_W-1:0] :
                     (acc_r[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : {1'b0, {(DATA_W-1){1'b1}}});

  // Result queue. Reservations taken at issue keep it from overflowing.
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (s3_done_r) begin
      oq_idx[oq_wr_ptr_r]  <= s3_n_r;
      oq_val[oq_wr_ptr_r]  <= sat_val;
      oq_sat[oq_wr_ptr_r]  <= !fits;
      oq_last[oq_wr_ptr_r] <= s3_lastrun_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_ptr_r <= '0;
      oq_rd_ptr_r <= '0;
      oq_cnt_r    <= '0;
      res_cnt_r   <= '0;
    end else begin
      if (s3_done_r) begin
        oq_wr_ptr_r <= (oq_wr_ptr_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_wr_ptr_r + 1'b1;
      end
      if (out_xfer) begin
        oq_rd_ptr_r <= (oq_rd_ptr_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_rd_ptr_r + 1'b1;
      end
      if (s3_done_r && !out_xfer) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (!s3_done_r && out_xfer) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
      if (issue && k_r == '0 && !out_xfer) begin
        res_cnt_r <= res_cnt_r + 1'b1;
      end else if (!(issue && k_r == '0) && out_xfer) begin
        res_cnt_r <= res_cnt_r - 1'b1;
      end
    end
  end

  assign out_valid       = (oq_cnt_r != '0);
  assign out_index       = oq_idx[oq_rd_ptr_r];
  assign out_value       = signed'(oq_val[oq_rd_ptr_r]);
  assign out_saturated   = oq_sat[oq_rd_ptr_r];
  assign out_last_of_run = oq_last[oq_rd_ptr_r];

endmodule

// File: src/matrix4x4_multiply.sv
// Load items at the queue head are taken into the stores by the back while it is idle; the front
// queue holds four and accepts while the back computes.
// A run computes MATRIX_DIM*MATRIX_DIM elements of MATRIX_DIM products each through
// one 32x32 multiplier; a new element waits while no result slot is free.
// Each result passes the store read, the product, the accumulation and the result queue in order.
// Reset (synchronous, active low) empties both queues and clears per-entry valid
// bits, so every store entry reads as zero at once; no clearing pass is needed.
`timescale 1ns / 1ps

module matrix4x4_multiply
  import mm4x4_pkg::*;
#(
  parameter int MATRIX_DIM = DIM_DEFAULT,
  parameter int FRAC_BITS  = FRAC_DEFAULT,
  parameter int IDX_W      = $clog2(MATRIX_DIM * MATRIX_DIM)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IDX_W-1:0]         in_elem_index,
  input  logic signed [DATA_W-1:0] in_a_element,
  input  logic signed [DATA_W-1:0] in_b_element,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_index,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_saturated,
  output logic                     out_last_of_run
);

  localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;

  logic              q_valid;
  item_kind_t        q_kind;
  logic [IDX_W-1:0]  q_idx;
  logic [DATA_W-1:0] q_a;
  logic [DATA_W-1:0] q_b;
  logic              q_pop;

  mm4x4_front #(
    .MATRIX_DIM (MATRIX_DIM),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_elem_index (in_elem_index),
    .in_a_element  (in_a_element),
    .in_b_element  (in_b_element),
    .q_valid       (q_valid),
    .q_kind        (q_kind),
    .q_idx         (q_idx),
    .q_a           (q_a),
    .q_b           (q_b),
    .q_pop         (q_pop)
  );

  mm4x4_back #(
    .MATRIX_DIM (MATRIX_DIM),
    .FRAC_BITS  (FRAC_BITS),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_kind          (q_kind),
    .q_idx           (q_idx),
    .q_a             (q_a),
    .q_b             (q_b),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_index       (out_index),
    .out_value       (out_value),
    .out_saturated   (out_saturated),
    .out_last_of_run (out_last_of_run)
  );

  // The back never pops an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A stalled input means the queue is full, so the back has work waiting.
  assert property (@(posedge clk) disable iff (!rst_n) (in_valid && !in_ready) |-> q_valid)
    else $error("input stalled with an empty queue");

  // The last transfer of a run carries the final row-major position.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_of_run) |-> (out_index == IDX_W'(ELEM_COUNT - 1)))
    else $error("last result flag on wrong position");

  // Popping a trigger starts a run, so the queue is not popped on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_kind == KIND_TRIGGER) |=> !q_pop)
    else $error("queue popped during a run");

endmodule
